/* rtl/core/ppc_relocation_patcher_unit_macros.svh */
// ---------------------------------------------------------------------------
// PowerPC relocation patcher assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef PPC_RELOCATION_PATCHER_UNIT_MACROS_SVH
`define PPC_RELOCATION_PATCHER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPC_RP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppc relocation patcher assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PPC_RP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppc relocation patcher assertion failed");

// Consequent given as a sequence, which may start with a fixed delay.
`define PPC_RP_ASSERT_SEQ(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("ppc relocation patcher assertion failed");

`endif

/* rtl/core/ppc_rp_pkg.sv */
// ---------------------------------------------------------------------------
// PowerPC relocation patcher package
// Relocation type codes, decoded method and field form, queue entry type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppc_rp_pkg;

    // Relocation type numbers from the PowerPC ELF32 ABI.
    localparam logic [7:0] R_ADDR32          = 8'd1;
    localparam logic [7:0] R_ADDR24          = 8'd2;
    localparam logic [7:0] R_ADDR16          = 8'd3;
    localparam logic [7:0] R_ADDR16_LO       = 8'd4;
    localparam logic [7:0] R_ADDR16_HI       = 8'd5;
    localparam logic [7:0] R_ADDR16_HA       = 8'd6;
    localparam logic [7:0] R_ADDR14          = 8'd7;
    localparam logic [7:0] R_ADDR14_BRTAKEN  = 8'd8;
    localparam logic [7:0] R_ADDR14_BRNTAKEN = 8'd9;
    localparam logic [7:0] R_REL24           = 8'd10;
    localparam logic [7:0] R_REL14           = 8'd11;
    localparam logic [7:0] R_REL14_BRTAKEN   = 8'd12;
    localparam logic [7:0] R_REL14_BRNTAKEN  = 8'd13;
    localparam logic [7:0] R_PLTREL24        = 8'd18;
    localparam logic [7:0] R_LOCAL24PC       = 8'd23;
    localparam logic [7:0] R_UADDR32         = 8'd24;
    localparam logic [7:0] R_UADDR16         = 8'd25;
    localparam logic [7:0] R_REL32           = 8'd26;
    localparam logic [7:0] R_SECTOFF         = 8'd33;
    localparam logic [7:0] R_SECTOFF_LO      = 8'd34;
    localparam logic [7:0] R_SECTOFF_HI      = 8'd35;
    localparam logic [7:0] R_SECTOFF_HA      = 8'd36;
    localparam logic [7:0] R_ADDR30          = 8'd37;
    localparam logic [7:0] R_EMB_NADDR32     = 8'd101;
    localparam logic [7:0] R_EMB_NADDR16     = 8'd102;
    localparam logic [7:0] R_EMB_NADDR16_LO  = 8'd103;
    localparam logic [7:0] R_EMB_NADDR16_HI  = 8'd104;
    localparam logic [7:0] R_EMB_NADDR16_HA  = 8'd105;

    // Field masks.
    localparam logic [31:0] MASK_B24_KEEP  = 32'hfc000003;
    localparam logic [31:0] MASK_B24_VAL   = 32'h03fffffc;
    localparam logic [31:0] MASK_B14_KEEP  = 32'hffff0003;
    localparam logic [31:0] MASK_B14_VAL   = 32'h0000fffc;
    localparam logic [31:0] MASK_B14H_KEEP = 32'hffdf0003;
    localparam logic [31:0] BIT_BR_TAKEN   = 32'h00200000;
    localparam logic [31:0] MASK_W30_KEEP  = 32'h00000003;
    localparam logic [31:0] MASK_W30_VAL   = 32'hfffffffc;

    localparam logic STORE_WORD = 1'b0;
    localparam logic STORE_HALF = 1'b1;
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_BAD   = 1'b1;

    typedef enum logic [1:0] {
        METH_ABS  = 2'd0,
        METH_REL  = 2'd1,
        METH_SECT = 2'd2,
        METH_NEG  = 2'd3
    } method_t;

    typedef enum logic [3:0] {
        FORM_W32  = 4'd0,
        FORM_B24  = 4'd1,
        FORM_H16  = 4'd2,
        FORM_HI   = 4'd3,
        FORM_HA   = 4'd4,
        FORM_LO   = 4'd5,
        FORM_B14  = 4'd6,
        FORM_B14T = 4'd7,
        FORM_B14N = 4'd8,
        FORM_W30  = 4'd9
    } form_t;

    // One classified item as it waits between front and back.
    typedef struct packed {
        logic        known;
        method_t     method;
        form_t       form;
        logic [31:0] target;
        logic [31:0] sum_sa;
        logic [31:0] sum_sect;
        logic [31:0] diff_neg;
        logic [31:0] old_word;
    } entry_t;

endpackage

/* rtl/core/ppc_rp_front.sv */
// ---------------------------------------------------------------------------
// PowerPC relocation patcher front end
// Holds the load base, decodes the type and forms the operand sums.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_rp_front
    import ppc_rp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic [7:0]  reloc_type,
    input  logic [31:0] offset,
    input  logic signed [31:0] addend,
    input  logic [31:0] symbol_address,
    input  logic [31:0] old_word,
    output entry_t      entry
);

    logic [31:0] load_base_reg;
    logic [31:0] load_base_next;
    logic [31:0] addend_u;
    logic        known;
    method_t     method;
    form_t       form;

    assign load_base_next = cfg_we ? cfg_wdata : load_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_base_reg <= 32'd0;
        end
        else
        begin
            load_base_reg <= load_base_next;
        end
    end

    always_comb
    begin
        known  = 1'b1;
        method = METH_ABS;
        form   = FORM_W32;
        case (reloc_type)
            R_ADDR32:          begin method = METH_ABS;  form = FORM_W32;  end
            R_ADDR24:          begin method = METH_ABS;  form = FORM_B24;  end
            R_ADDR16:          begin method = METH_ABS;  form = FORM_H16;  end
            R_ADDR16_LO:       begin method = METH_ABS;  form = FORM_LO;   end
            R_ADDR16_HI:       begin method = METH_ABS;  form = FORM_HI;   end
            R_ADDR16_HA:       begin method = METH_ABS;  form = FORM_HA;   end
            R_ADDR14:          begin method = METH_ABS;  form = FORM_B14;  end
            R_ADDR14_BRTAKEN:  begin method = METH_ABS;  form = FORM_B14T; end
            R_ADDR14_BRNTAKEN: begin method = METH_ABS;  form = FORM_B14N; end
            R_REL24:           begin method = METH_REL;  form = FORM_B24;  end
            R_REL14:           begin method = METH_REL;  form = FORM_B14;  end
            R_REL14_BRTAKEN:   begin method = METH_REL;  form = FORM_B14T; end
            R_REL14_BRNTAKEN:  begin method = METH_REL;  form = FORM_B14N; end
            R_PLTREL24:        begin method = METH_REL;  form = FORM_B24;  end
            R_LOCAL24PC:       begin method = METH_REL;  form = FORM_B24;  end
            R_UADDR32:         begin method = METH_ABS;  form = FORM_W32;  end
            R_UADDR16:         begin method = METH_ABS;  form = FORM_H16;  end
            R_REL32:           begin method = METH_REL;  form = FORM_W32;  end
            R_SECTOFF:         begin method = METH_SECT; form = FORM_W32;  end
            R_SECTOFF_LO:      begin method = METH_SECT; form = FORM_LO;   end
            R_SECTOFF_HI:      begin method = METH_SECT; form = FORM_HI;   end
            R_SECTOFF_HA:      begin method = METH_SECT; form = FORM_HA;   end
            R_ADDR30:          begin method = METH_REL;  form = FORM_W30;  end
            R_EMB_NADDR32:     begin method = METH_NEG;  form = FORM_W32;  end
            R_EMB_NADDR16:     begin method = METH_NEG;  form = FORM_H16;  end
            R_EMB_NADDR16_LO:  begin method = METH_NEG;  form = FORM_LO;   end
            R_EMB_NADDR16_HI:  begin method = METH_NEG;  form = FORM_HI;   end
            R_EMB_NADDR16_HA:  begin method = METH_NEG;  form = FORM_HA;   end
            default:           known = 1'b0;
        endcase
    end

    assign addend_u = $unsigned(addend);

    // Every candidate sum is formed here so the back end needs one subtract at most.
    always_comb
    begin
        entry.known    = known;
        entry.method   = method;
        entry.form     = form;
        entry.target   = load_base_reg + offset;
        entry.sum_sa   = symbol_address + addend_u;
        entry.sum_sect = offset + addend_u;
        entry.diff_neg = addend_u - symbol_address;
        entry.old_word = old_word;
    end

endmodule

/* rtl/core/ppc_rp_queue.sv */
// ---------------------------------------------------------------------------
// PowerPC relocation patcher decoupling queue
// Short register queue of classified items between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_rp_queue
    import ppc_rp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_data,
    input  logic   rd_en,
    output entry_t rd_data,
    output logic   full,
    output logic   not_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/ppc_rp_back.sv */
// ---------------------------------------------------------------------------
// PowerPC relocation patcher back end
// Selects the relocation value, merges it into the field, holds the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_rp_back
    import ppc_rp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  logic        head_valid,
    output logic        head_take,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] target_address,
    output logic [31:0] patched_value,
    output logic        store_width,
    output logic        status
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] target_reg;
    logic [31:0] value_reg;
    logic        width_reg;
    logic        status_reg;
    logic [31:0] v;
    logic [15:0] ha_half;
    logic [31:0] res;
    logic        half;

    // The output register reloads whenever the queue holds an item and the register is free or its item leaves.
    assign head_take      = head_valid && (!out_valid_reg || pop);
    assign out_valid_next = head_take ? 1'b1 : (pop ? 1'b0 : out_valid_reg);

    always_comb
    begin
        case (head.method)
            METH_ABS:  v = head.sum_sa;
            METH_REL:  v = head.sum_sa - head.target;
            METH_SECT: v = head.sum_sect;
            METH_NEG:  v = head.diff_neg;
            default:   v = head.sum_sa;
        endcase
    end

    // HA rounds the high half up when the low half will read as negative.
    assign ha_half = v[31:16] + {15'd0, v[15]};

    always_comb
    begin
        res  = head.old_word;
        half = STORE_WORD;
        if (head.known)
        begin
            case (head.form)
                FORM_W32: res = v;
                FORM_B24: res = (head.old_word & MASK_B24_KEEP) | (v & MASK_B24_VAL);
                FORM_H16:
                begin
                    res  = {16'd0, v[15:0]};
                    half = STORE_HALF;
                end
                FORM_HI:
                begin
                    res  = {16'd0, v[31:16]};
                    half = STORE_HALF;
                end
                FORM_HA:
                begin
                    res  = {16'd0, ha_half};
                    half = STORE_HALF;
                end
                FORM_LO:
                begin
                    res  = {16'd0, v[15:0]};
                    half = STORE_HALF;
                end
                FORM_B14: res = (head.old_word & MASK_B14_KEEP) | (v & MASK_B14_VAL);
                FORM_B14T:
                    res = (head.old_word & MASK_B14H_KEEP) | (v & MASK_B14_VAL)
                          | BIT_BR_TAKEN;
                FORM_B14N: res = (head.old_word & MASK_B14H_KEEP) | (v & MASK_B14_VAL);
                FORM_W30: res = (head.old_word & MASK_W30_KEEP) | (v & MASK_W30_VAL);
                default:  res = v;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_take)
        begin
            target_reg <= head.target;
            value_reg  <= res;
            width_reg  <= half;
            status_reg <= head.known ? STAT_OK : STAT_BAD;
        end
    end

    assign empty          = !out_valid_reg;
    assign target_address = target_reg;
    assign patched_value  = value_reg;
    assign store_width    = width_reg;
    assign status         = status_reg;

endmodule

/* rtl/core/ppc_relocation_patcher_unit.sv */
// ---------------------------------------------------------------------------
// PowerPC ELF32 relocation patcher
// Applies one relocation per item and gives the patch address and new data.
// ---------------------------------------------------------------------------
//   Channel  | Handshake        | Payload
//   ---------+------------------+-------------------------------------------
//   config   | cfg_we           | cfg_wdata (load base)
//   input    | push / full      | reloc_type, offset, addend, symbol_address,
//            |                  | old_word
//   result   | empty / pop      | target_address, patched_value,
//            |                  | store_width, status
//
// One item per cycle sustained while results are popped. At the earliest, an
// accepted item is written into the queue by the edge that accepts it and is
// then loaded into the output register that drives the result ports. The queue
// of QUEUE_DEPTH items lets the input side keep taking items while results are
// not popped; full rises once it and the output register are occupied. Reset
// clears the load base, the queue and the output valid flag at once.
`timescale 1ns / 1ps

module ppc_relocation_patcher_unit
    import ppc_rp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  reloc_type,
    input  logic [31:0] offset,
    input  logic signed [31:0] addend,
    input  logic [31:0] symbol_address,
    input  logic [31:0] old_word,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] target_address,
    output logic [31:0] patched_value,
    output logic        store_width,
    output logic        status
);

    entry_t front_entry;
    entry_t head_entry;
    logic   queue_full;
    logic   queue_not_empty;
    logic   head_take;
    logic   item_in;

    assign item_in = push && !queue_full;
    assign full    = queue_full;

    ppc_rp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .reloc_type     (reloc_type),
        .offset         (offset),
        .addend         (addend),
        .symbol_address (symbol_address),
        .old_word       (old_word),
        .entry          (front_entry)
    );

    ppc_rp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (item_in),
        .wr_data   (front_entry),
        .rd_en     (head_take),
        .rd_data   (head_entry),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    ppc_rp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head_entry),
        .head_valid     (queue_not_empty),
        .head_take      (head_take),
        .pop            (pop),
        .empty          (empty),
        .target_address (target_address),
        .patched_value  (patched_value),
        .store_width    (store_width),
        .status         (status)
    );

endmodule

/* rtl/core/ppc_rp_checker.sv */
// ---------------------------------------------------------------------------
// PowerPC relocation patcher port checker
// Watches the top-level ports for ordering and result consistency.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ppc_relocation_patcher_unit_macros.svh"

module ppc_rp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] patched_value,
    input logic        store_width,
    input logic        status
);

    // A waiting result stays until it is taken.
    `PPC_RP_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)

    // An unknown type never asks for a halfword store.
    `PPC_RP_ASSERT_SAME(a_bad_is_word, !empty && status, !store_width)

    // A halfword result leaves the upper half clear.
    `PPC_RP_ASSERT_SAME(a_half_upper_zero, !empty && store_width, patched_value[31:16] == 16'd0)

    // After an accepted item passes through the queue, the output register holds a result.
    `PPC_RP_ASSERT_SEQ(a_item_reaches_out, push && !full, ##2 (!empty))

endmodule

bind ppc_relocation_patcher_unit ppc_rp_checker u_ppc_rp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .patched_value (patched_value),
    .store_width   (store_width),
    .status        (status)
);
